// File: src/rppt_pkg.sv
`timescale 1ns / 1ps

package rppt_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int COORD_BITS_DEF  = 24;

    localparam int IDX_OUT_W       = 10;
    localparam int MM_W            = 24;
    localparam int L8_W            = 33;
    localparam int SQ_EXT_W        = 68;
    localparam int OUT_DATA_W      = 96;

    localparam logic [MM_W-1:0] MM_MAX  = '1;
    localparam logic [L8_W-1:0] L8_SAT  = 33'h1_0000_0000;
    localparam logic [MM_W-1:0] THR_MIN = 24'd20;

    localparam logic [2:0] CMD_LOAD       = 3'd0;
    localparam logic [2:0] CMD_INVALIDATE = 3'd1;
    localparam logic [2:0] CMD_ADVANCE    = 3'd2;
    localparam logic [2:0] CMD_PROGRESS   = 3'd3;
    localparam logic [2:0] CMD_NEAREST    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PATH = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    // what a read issued into the distance pipeline is for
    typedef enum logic [1:0] {
        K_BEST,
        K_SEG,
        K_PRIME,
        K_DIRECT
    } kind_t;

    typedef struct packed {
        logic  capture;
        logic  wr_en;
        logic  issue;
        kind_t kind;
        logic  scan_clear;
        logic  acc_clear;
        logic  acc_add;
        logic  sqrt_start;
        logic  sqrt_best;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic sqrt_busy;
        logic rem_sat;
        logic rem_le_thr;
        logic direct_le_thr;
    } dp_stat_t;

    // 8-fraction-bit length to rounded mm, saturating
    function automatic logic [MM_W-1:0] l8_to_mm(input logic [L8_W-1:0] l8);
        logic [L8_W:0] r;
        begin
            r = ({1'b0, l8} + (L8_W + 1)'(128)) >> 8;
            if (l8[L8_W-1])
            begin
                l8_to_mm = MM_MAX;
            end
            else if (r > (L8_W + 1)'(MM_MAX))
            begin
                l8_to_mm = MM_MAX;
            end
            else
            begin
                l8_to_mm = r[MM_W-1:0];
            end
        end
    endfunction

endpackage

// File: src/rppt_sqrt.sv
`timescale 1ns / 1ps

module rppt_sqrt #(
    parameter int SQ_W = 51
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [SQ_W-1:0]           operand,
    output logic                      busy,
    output logic [rppt_pkg::L8_W-1:0] root
);
    import rppt_pkg::*;

    logic [SQ_EXT_W-1:0] sq_ext;
    logic [63:0]         v_reg;
    logic [63:0]         r_reg;
    logic [63:0]         b_reg;
    logic                busy_reg;
    logic [63:0]         trial;
    logic                fits;

    assign sq_ext = SQ_EXT_W'(operand);
    assign trial  = r_reg + b_reg;
    assign fits   = v_reg >= trial;
    assign busy   = busy_reg;
    assign root   = r_reg[L8_W-1:0];

    // one result bit a cycle, 32 steps; an operand above 48 bits saturates the root instead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            v_reg    <= '0;
            r_reg    <= '0;
            b_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
            if (b_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
        else if (start)
        begin
            if (|sq_ext[SQ_EXT_W-1:48])
            begin
                r_reg <= 64'(L8_SAT);
            end
            else
            begin
                v_reg    <= {sq_ext[47:0], 16'd0};
                r_reg    <= '0;
                b_reg    <= 64'd1 << 62;
                busy_reg <= 1'b1;
            end
        end
    end

endmodule

// File: src/rppt_dp.sv
`timescale 1ns / 1ps

module rppt_dp #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rppt_pkg::dp_cmd_t                cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]    addr,
    input  logic signed [COORD_BITS-1:0]     point_x,
    input  logic signed [COORD_BITS-1:0]     point_y,
    input  logic signed [COORD_BITS-1:0]     robot_x,
    input  logic signed [COORD_BITS-1:0]     robot_y,
    input  logic [rppt_pkg::MM_W-1:0]        pass_threshold,
    output rppt_pkg::dp_stat_t               stat,
    output logic [$clog2(MAX_POINTS)-1:0]    best_idx,
    output logic [rppt_pkg::MM_W-1:0]        root_mm,
    output logic [rppt_pkg::MM_W-1:0]        rem_mm
);
    import rppt_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int MW    = COORD_BITS + 1;
    localparam int SQ_W  = 2 * MW + 1;
    localparam int PT_W  = 2 * COORD_BITS;

    logic [PT_W-1:0] mem [MAX_POINTS];

    logic signed [COORD_BITS-1:0] px_reg, py_reg, rx_reg, ry_reg;
    logic signed [COORD_BITS-1:0] prevx_reg, prevy_reg;
    logic [MM_W-1:0]              thr_reg;
    logic [2*MM_W-1:0]            thr_sq_reg;

    logic [PT_W-1:0]  q_reg;
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    kind_t            kind1_reg, kind2_reg, kind3_reg, kind4_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [MW-1:0]    mx_reg, my_reg;
    logic [2*MW-1:0]  sqx_reg, sqy_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [SQ_W-1:0]  best_sq_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             best_ok_reg;
    logic [SQ_W-1:0]  last_sq_reg;
    logic [L8_W-1:0]  rem_reg;

    logic signed [COORD_BITS-1:0] qx, qy, ax, ay, bx, by;
    logic [L8_W-1:0]              root_l8;
    logic [L8_W:0]                rem_sum;
    logic                         sqrt_busy;

    function automatic logic [MW-1:0] mag(input logic signed [COORD_BITS-1:0] a,
                                          input logic signed [COORD_BITS-1:0] b);
        logic signed [MW-1:0] d;
        begin
            d = MW'(a) - MW'(b);
            mag = d[MW-1] ? MW'(-d) : MW'(d);
        end
    endfunction

    assign qx = q_reg[COORD_BITS-1:0];
    assign qy = q_reg[PT_W-1:COORD_BITS];

    always_comb
    begin
        ax = qx;
        ay = qy;
        bx = px_reg;
        by = py_reg;
        case (kind1_reg)
            K_SEG:
            begin
                bx = prevx_reg;
                by = prevy_reg;
            end
            K_DIRECT:
            begin
                ax = px_reg;
                ay = py_reg;
                bx = rx_reg;
                by = ry_reg;
            end
            default:
            begin
                bx = px_reg;
                by = py_reg;
            end
        endcase
    end

    // store and distance pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= {py_reg, px_reg};
        end
        q_reg <= mem[addr];
        if (cmd.capture)
        begin
            px_reg  <= point_x;
            py_reg  <= point_y;
            rx_reg  <= robot_x;
            ry_reg  <= robot_y;
            thr_reg <= (pass_threshold < THR_MIN) ? THR_MIN : pass_threshold;
        end
        thr_sq_reg <= thr_reg * thr_reg;
        idx1_reg   <= addr;
        kind1_reg  <= cmd.kind;
        mx_reg     <= mag(ax, bx);
        my_reg     <= mag(ay, by);
        idx2_reg   <= idx1_reg;
        kind2_reg  <= kind1_reg;
        if (v1_reg && (kind1_reg == K_PRIME || kind1_reg == K_SEG))
        begin
            prevx_reg <= qx;
            prevy_reg <= qy;
        end
        sqx_reg   <= mx_reg * mx_reg;
        sqy_reg   <= my_reg * my_reg;
        idx3_reg  <= idx2_reg;
        kind3_reg <= kind2_reg;
        sq_reg    <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
        idx4_reg  <= idx3_reg;
        kind4_reg <= kind3_reg;
        if (v4_reg)
        begin
            if (kind4_reg == K_BEST)
            begin
                if (!best_ok_reg || sq_reg < best_sq_reg)
                begin
                    best_sq_reg  <= sq_reg;
                    best_idx_reg <= idx4_reg;
                end
            end
            else
            begin
                last_sq_reg <= sq_reg;
            end
        end
    end

    assign rem_sum = {1'b0, rem_reg} + {1'b0, root_l8};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            best_ok_reg <= 1'b0;
            rem_reg     <= '0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg && kind1_reg != K_PRIME;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.scan_clear)
            begin
                best_ok_reg <= 1'b0;
            end
            else if (v4_reg && kind4_reg == K_BEST)
            begin
                best_ok_reg <= 1'b1;
            end
            if (cmd.acc_clear)
            begin
                rem_reg <= '0;
            end
            else if (cmd.acc_add)
            begin
                rem_reg <= (rem_sum > (L8_W + 1)'(L8_SAT)) ? L8_SAT : rem_sum[L8_W-1:0];
            end
        end
    end

    rppt_sqrt #(
        .SQ_W (SQ_W)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sqrt_start),
        .operand (cmd.sqrt_best ? best_sq_reg : last_sq_reg),
        .busy    (sqrt_busy),
        .root    (root_l8)
    );

    assign stat.pipe_busy     = v1_reg | v2_reg | v3_reg | v4_reg;
    assign stat.sqrt_busy     = sqrt_busy;
    assign stat.rem_sat       = rem_reg[L8_W-1];
    assign stat.rem_le_thr    = rem_reg <= {1'b0, thr_reg, 8'd0};
    assign stat.direct_le_thr = SQ_EXT_W'(last_sq_reg) <= SQ_EXT_W'(thr_sq_reg);
    assign best_idx           = best_idx_reg;
    assign root_mm            = l8_to_mm(root_l8);
    assign rem_mm             = l8_to_mm(rem_reg);

endmodule

// File: src/rppt_ctrl.sv
`timescale 1ns / 1ps

module rppt_ctrl #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [2:0]                       command,
    input  logic                             last_point,
    input  logic [rppt_pkg::IDX_OUT_W-1:0]   target_index,
    input  logic                             hold_before_end,
    output rppt_pkg::dp_cmd_t                dp_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]    addr,
    input  rppt_pkg::dp_stat_t               stat,
    input  logic [$clog2(MAX_POINTS)-1:0]    best_idx,
    input  logic [rppt_pkg::MM_W-1:0]        root_mm,
    input  logic [rppt_pkg::MM_W-1:0]        rem_mm,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [1:0]                       status,
    output logic                             path_ok,
    output logic [rppt_pkg::IDX_OUT_W-1:0]   result_index,
    output logic [rppt_pkg::MM_W-1:0]        distance_mm,
    output logic [rppt_pkg::MM_W-1:0]        direct_goal_mm,
    output logic                             reached,
    output logic [31:0]                      version
);
    import rppt_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CW    = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SCAN_WAIT,
        S_NSQRT,
        S_NSQRT_WAIT,
        S_PRIME,
        S_PRIME_WAIT,
        S_SEG_ISSUE,
        S_SEG_WAIT,
        S_SEG_SQRT,
        S_SEG_SQRT_WAIT,
        S_DIR_ISSUE,
        S_DIR_WAIT,
        S_DIR_SQRT,
        S_DIR_SQRT_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [2:0]           cmd_reg;
    logic                 last_reg;
    logic [IDX_OUT_W-1:0] target_reg;
    logic                 hold_reg;

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] cursor_reg;
    logic             held_reg;
    logic             loading_reg;
    logic [31:0]      version_reg;

    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [CNT_W-1:0] seg_idx_reg;

    logic [1:0]       res_status_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic [MM_W-1:0]  res_dist_reg;
    logic [MM_W-1:0]  res_direct_reg;
    logic             res_reached_reg;

    logic                 m_tvalid_reg;
    logic [1:0]           status_reg;
    logic                 path_ok_reg;
    logic [IDX_OUT_W-1:0] result_index_reg;
    logic [MM_W-1:0]      distance_reg;
    logic [MM_W-1:0]      direct_reg;
    logic                 reached_reg;
    logic [31:0]          version_out_reg;

    logic [CNT_W-1:0] count_eff;
    logic             ld_fit;
    logic [CNT_W-1:0] ld_count;
    logic             ld_held;
    logic [CW-1:0]    adv_top;
    logic [CW-1:0]    adv_want;
    logic [CW-1:0]    adv_cursor;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] cur_eff;
    logic             seg_go;
    logic             no_segments;
    logic             out_load;

    assign count_eff = loading_reg ? count_reg : '0;
    assign ld_fit    = count_eff < CNT_W'(MAX_POINTS);
    assign ld_count  = ld_fit ? count_eff + CNT_W'(1) : count_eff;
    assign ld_held   = ld_count >= CNT_W'(2);

    always_comb
    begin
        adv_top = CW'(count_reg) - CW'(1);
        if (hold_reg && adv_top != '0)
        begin
            adv_top = adv_top - CW'(1);
        end
        adv_want   = (CW'(target_reg) > CW'(cursor_reg)) ? CW'(target_reg) : CW'(cursor_reg);
        adv_cursor = (adv_want < adv_top) ? adv_want : adv_top;
    end

    assign last_idx    = IDX_W'(count_reg - CNT_W'(1));
    assign cur_eff     = (cursor_reg < last_idx) ? cursor_reg : last_idx;
    assign seg_go      = seg_idx_reg <= CNT_W'(best_idx) && !stat.rem_sat;
    assign no_segments = cur_reg >= best_idx;
    assign s_tready    = state_reg == S_IDLE;
    assign out_load    = state_reg == S_OUT && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        dp_cmd         = '0;
        dp_cmd.kind    = K_BEST;
        dp_cmd.capture = s_tvalid && state_reg == S_IDLE;
        addr           = scan_idx_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                if (cmd_reg == CMD_LOAD && ld_fit)
                begin
                    dp_cmd.wr_en = 1'b1;
                    addr         = IDX_W'(count_eff);
                end
                dp_cmd.scan_clear = 1'b1;
                dp_cmd.acc_clear  = 1'b1;
            end
            S_SCAN:
            begin
                dp_cmd.issue = 1'b1;
            end
            S_NSQRT:
            begin
                dp_cmd.sqrt_start = 1'b1;
                dp_cmd.sqrt_best  = 1'b1;
            end
            S_PRIME:
            begin
                dp_cmd.issue = !no_segments;
                dp_cmd.kind  = K_PRIME;
                addr         = cur_reg;
            end
            S_SEG_ISSUE:
            begin
                dp_cmd.issue = seg_go;
                dp_cmd.kind  = K_SEG;
                addr         = IDX_W'(seg_idx_reg);
            end
            S_SEG_SQRT, S_DIR_SQRT:
            begin
                dp_cmd.sqrt_start = 1'b1;
            end
            S_SEG_SQRT_WAIT:
            begin
                dp_cmd.acc_add = !stat.sqrt_busy;
            end
            S_DIR_ISSUE:
            begin
                dp_cmd.issue = 1'b1;
                dp_cmd.kind  = K_DIRECT;
            end
            default:
            begin
                dp_cmd.issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cmd_reg          <= '0;
            last_reg         <= 1'b0;
            target_reg       <= '0;
            hold_reg         <= 1'b0;
            count_reg        <= '0;
            cursor_reg       <= '0;
            held_reg         <= 1'b0;
            loading_reg      <= 1'b0;
            version_reg      <= '0;
            scan_idx_reg     <= '0;
            cur_reg          <= '0;
            seg_idx_reg      <= '0;
            res_status_reg   <= ST_OK;
            res_idx_reg      <= '0;
            res_dist_reg     <= '0;
            res_direct_reg   <= '0;
            res_reached_reg  <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            status_reg       <= ST_OK;
            path_ok_reg      <= 1'b0;
            result_index_reg <= '0;
            distance_reg     <= '0;
            direct_reg       <= '0;
            reached_reg      <= 1'b0;
            version_out_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg    <= command;
                        last_reg   <= last_point;
                        target_reg <= target_index;
                        hold_reg   <= hold_before_end;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_status_reg  <= ST_OK;
                    res_idx_reg     <= cursor_reg;
                    res_dist_reg    <= '0;
                    res_direct_reg  <= '0;
                    res_reached_reg <= 1'b0;
                    state_reg       <= S_OUT;
                    unique case (cmd_reg)
                        CMD_LOAD:
                        begin
                            count_reg      <= ld_count;
                            loading_reg    <= !last_reg;
                            res_status_reg <= ld_fit ? ST_OK : ST_DROPPED;
                            if (last_reg)
                            begin
                                cursor_reg  <= '0;
                                res_idx_reg <= '0;
                                held_reg    <= ld_held;
                                if (ld_held)
                                begin
                                    version_reg <= version_reg + 32'd1;
                                end
                                else if (ld_fit)
                                begin
                                    res_status_reg <= ST_NO_PATH;
                                end
                            end
                            else if (!loading_reg)
                            begin
                                cursor_reg  <= '0;
                                res_idx_reg <= '0;
                                held_reg    <= 1'b0;
                            end
                        end
                        CMD_INVALIDATE:
                        begin
                            held_reg    <= 1'b0;
                            loading_reg <= 1'b0;
                            count_reg   <= '0;
                            cursor_reg  <= '0;
                            res_idx_reg <= '0;
                        end
                        CMD_ADVANCE:
                        begin
                            if (!held_reg)
                            begin
                                cursor_reg     <= '0;
                                res_idx_reg    <= '0;
                                res_status_reg <= ST_NO_PATH;
                            end
                            else
                            begin
                                cursor_reg  <= IDX_W'(adv_cursor);
                                res_idx_reg <= IDX_W'(adv_cursor);
                            end
                        end
                        CMD_PROGRESS, CMD_NEAREST:
                        begin
                            if (!held_reg)
                            begin
                                res_status_reg <= ST_NO_PATH;
                                res_dist_reg   <= MM_MAX;
                                if (cmd_reg == CMD_PROGRESS)
                                begin
                                    res_direct_reg <= MM_MAX;
                                end
                            end
                            else
                            begin
                                cur_reg      <= cur_eff;
                                scan_idx_reg <= (cmd_reg == CMD_NEAREST) ? cur_eff : '0;
                                state_reg    <= S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_reg <= ST_OK;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    if (scan_idx_reg == last_idx)
                    begin
                        state_reg <= S_SCAN_WAIT;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end
                end
                S_SCAN_WAIT:
                begin
                    if (!stat.pipe_busy)
                    begin
                        state_reg <= (cmd_reg == CMD_NEAREST) ? S_NSQRT : S_PRIME;
                    end
                end
                S_NSQRT:
                begin
                    state_reg <= S_NSQRT_WAIT;
                end
                S_NSQRT_WAIT:
                begin
                    if (!stat.sqrt_busy)
                    begin
                        res_idx_reg  <= best_idx;
                        res_dist_reg <= root_mm;
                        state_reg    <= S_OUT;
                    end
                end
                S_PRIME:
                begin
                    seg_idx_reg <= CNT_W'(cur_reg) + CNT_W'(1);
                    state_reg   <= no_segments ? S_DIR_ISSUE : S_PRIME_WAIT;
                end
                S_PRIME_WAIT:
                begin
                    if (!stat.pipe_busy)
                    begin
                        state_reg <= S_SEG_ISSUE;
                    end
                end
                S_SEG_ISSUE:
                begin
                    state_reg <= seg_go ? S_SEG_WAIT : S_DIR_ISSUE;
                end
                S_SEG_WAIT:
                begin
                    if (!stat.pipe_busy)
                    begin
                        state_reg <= S_SEG_SQRT;
                    end
                end
                S_SEG_SQRT:
                begin
                    state_reg <= S_SEG_SQRT_WAIT;
                end
                S_SEG_SQRT_WAIT:
                begin
                    if (!stat.sqrt_busy)
                    begin
                        seg_idx_reg <= seg_idx_reg + CNT_W'(1);
                        state_reg   <= S_SEG_ISSUE;
                    end
                end
                S_DIR_ISSUE:
                begin
                    state_reg <= S_DIR_WAIT;
                end
                S_DIR_WAIT:
                begin
                    if (!stat.pipe_busy)
                    begin
                        state_reg <= S_DIR_SQRT;
                    end
                end
                S_DIR_SQRT:
                begin
                    state_reg <= S_DIR_SQRT_WAIT;
                end
                S_DIR_SQRT_WAIT:
                begin
                    if (!stat.sqrt_busy)
                    begin
                        res_idx_reg     <= best_idx;
                        res_dist_reg    <= rem_mm;
                        res_direct_reg  <= root_mm;
                        res_reached_reg <= no_segments || stat.rem_le_thr
                                           || stat.direct_le_thr;
                        state_reg       <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        status_reg       <= res_status_reg;
                        path_ok_reg      <= held_reg;
                        result_index_reg <= IDX_OUT_W'(res_idx_reg);
                        distance_reg     <= res_dist_reg;
                        direct_reg       <= res_direct_reg;
                        reached_reg      <= res_reached_reg;
                        version_out_reg  <= version_reg;
                        state_reg        <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign status         = status_reg;
    assign path_ok        = path_ok_reg;
    assign result_index   = result_index_reg;
    assign distance_mm    = distance_reg;
    assign direct_goal_mm = direct_reg;
    assign reached        = reached_reg;
    assign version        = version_out_reg;

`ifndef NO_ASSERTIONS
    a_cursor_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> (CNT_W'(cursor_reg) < count_reg))
        else $error("cursor beyond last point of held path");

    a_held_len: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> (count_reg >= CNT_W'(2)))
        else $error("path held with fewer than two points");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above store depth");

    a_unit_share: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.pipe_busy && stat.sqrt_busy))
        else $error("distance pipeline and square root busy together");
`endif

endmodule

// File: src/reference_path_progress_tracker.sv
`timescale 1ns / 1ps

// path tracker: holds a reference path and answers nearest-point and goal progress queries
// slave channel: one beat per command, tuser carries the command code, tlast marks the
// final point of a load; the block takes one beat at a time and gives exactly one
// result beat for each on the master channel (status in tuser)
// load, invalidate, advance and unknown commands: result set in EXEC, registered in OUT
// nearest query: the single store read port reads the cursor point to the last point
// into a five-stage distance pipeline, then a square root unit settles one bit per cycle
// progress query: every stored point is scanned, then the segments from the cursor to
// the goal index are summed, none when the cursor is already at or past the goal index;
// every polyline segment re-reads the store and takes its own square root pass
// reset clears the path, the cursor and the version; the point store is not cleared and
// needs no sweep, only points of the current load are ever read
// a stalled master side holds the result in the output register; the next command is
// still accepted and worked on, its result waits until the earlier one is taken
module reference_path_progress_tracker #(
    parameter int MAX_POINTS = rppt_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = rppt_pkg::COORD_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // point_x, point_y, robot_x, robot_y, target_index, hold_before_end, pass_threshold
    input  logic [((4*COORD_BITS+35+7)/8)*8-1:0]          s_tdata,
    // command
    input  logic [2:0]                                    s_tuser,
    input  logic                                          s_tlast,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // path_ok, result_index, distance_mm, direct_goal_mm, reached, version
    output logic [rppt_pkg::OUT_DATA_W-1:0]               m_tdata,
    // status
    output logic [1:0]                                    m_tuser
);
    import rppt_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CB    = COORD_BITS;

    dp_cmd_t              dp_cmd;
    dp_stat_t             dp_stat;
    logic [IDX_W-1:0]     addr;
    logic [IDX_W-1:0]     best_idx;
    logic [MM_W-1:0]      root_mm;
    logic [MM_W-1:0]      rem_mm;
    logic                 path_ok;
    logic [IDX_OUT_W-1:0] result_index;
    logic [MM_W-1:0]      distance_mm;
    logic [MM_W-1:0]      direct_goal_mm;
    logic                 reached;
    logic [31:0]          version;

    rppt_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .command         (s_tuser),
        .last_point      (s_tlast),
        .target_index    (s_tdata[4*CB+9:4*CB]),
        .hold_before_end (s_tdata[4*CB+10]),
        .dp_cmd          (dp_cmd),
        .addr            (addr),
        .stat            (dp_stat),
        .best_idx        (best_idx),
        .root_mm         (root_mm),
        .rem_mm          (rem_mm),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .status          (m_tuser),
        .path_ok         (path_ok),
        .result_index    (result_index),
        .distance_mm     (distance_mm),
        .direct_goal_mm  (direct_goal_mm),
        .reached         (reached),
        .version         (version)
    );

    rppt_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .addr           (addr),
        .point_x        (s_tdata[CB-1:0]),
        .point_y        (s_tdata[2*CB-1:CB]),
        .robot_x        (s_tdata[3*CB-1:2*CB]),
        .robot_y        (s_tdata[4*CB-1:3*CB]),
        .pass_threshold (s_tdata[4*CB+34:4*CB+11]),
        .stat           (dp_stat),
        .best_idx       (best_idx),
        .root_mm        (root_mm),
        .rem_mm         (rem_mm)
    );

    assign m_tdata = {4'd0, version, reached, direct_goal_mm, distance_mm,
                      result_index, path_ok};

endmodule

// File: dv/reference_path_progress_tracker_test.sv
`timescale 1ns / 1ps

module reference_path_progress_tracker_test;

    import rppt_pkg::*;

    localparam logic [2:0] CMD_NOP5       = 3'd5;
    localparam logic [2:0] CMD_NOP6       = 3'd6;
    localparam logic [2:0] CMD_NOP7       = 3'd7;

    localparam int PATH_DEPTH   = 1024;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int RANDOM_ITEMS = 265;
    localparam logic signed [23:0] C_MIN = 24'sh800000;
    localparam logic signed [23:0] C_MAX = 24'sh7FFFFF;
    localparam longint unsigned LEN_SAT = 64'h1_0000_0000;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] rx;
        logic signed [23:0] ry;
        logic               last;
        logic [9:0]         tgt;
        logic               hold;
        logic [23:0]        thr;
    } cmd_beat_t;

    typedef struct {
        logic [1:0]  status;
        logic        ok;
        logic [9:0]  idx;
        logic [23:0] distance;
        logic [23:0] direct;
        logic        reached;
        logic [31:0] version;
    } track_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    reference_path_progress_tracker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // tracker shadow state
    logic signed [23:0] path_x [PATH_DEPTH];
    logic signed [23:0] path_y [PATH_DEPTH];
    int unsigned        n_points;
    int unsigned        cursor;
    bit                 held;
    bit                 loading;
    logic [31:0]        commits;

    track_result_t expected_results [$];
    cmd_beat_t     table_beats [$];
    bit            table_typed [$];
    track_result_t table_result [$];

    int  errors;
    int  cycles;
    int  results_seen;
    int  cmd_hits [8];
    int  random_sent;
    bit  quiet;
    int  rx_stall;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
        begin
            b >>= 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned dist_sq(logic signed [23:0] ax, logic signed [23:0] ay,
                                                logic signed [23:0] bx, logic signed [23:0] by);
        longint dx;
        longint dy;
        longint unsigned mx;
        longint unsigned my;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        return mx * mx + my * my;
    endfunction

    // length in mm with 8 fraction bits, saturating at 2^24 mm
    function automatic longint unsigned span_l8(longint unsigned sq);
        if (sq >= 64'h1_0000_0000_0000)
        begin
            return LEN_SAT;
        end
        return isqrt(sq << 16);
    endfunction

    function automatic logic [23:0] round_mm(longint unsigned l8);
        longint unsigned r;
        if (l8 >= LEN_SAT)
        begin
            return 24'hFFFFFF;
        end
        r = (l8 + 128) >> 8;
        return r > 64'hFFFFFF ? 24'hFFFFFF : r[23:0];
    endfunction

    function automatic track_result_t track_step(cmd_beat_t b);
        track_result_t   r;
        longint unsigned thr;
        longint unsigned best_sq;
        longint unsigned sq;
        longint unsigned rem;
        int unsigned     i;
        int unsigned     best;
        int unsigned     cur;
        int unsigned     top;
        int unsigned     want;
        r = '{default: '0};
        thr = b.thr < 20 ? 20 : b.thr;
        case (b.cmd)
            CMD_LOAD:
            begin
                if (!loading)
                begin
                    loading = 1;
                    held = 0;
                    n_points = 0;
                    cursor = 0;
                end
                if (n_points < PATH_DEPTH)
                begin
                    path_x[n_points] = b.px;
                    path_y[n_points] = b.py;
                    n_points++;
                end
                else
                begin
                    r.status = ST_DROPPED;
                end
                if (b.last)
                begin
                    loading = 0;
                    cursor = 0;
                    held = n_points >= 2;
                    if (held)
                    begin
                        commits++;
                    end
                    else if (r.status == ST_OK)
                    begin
                        r.status = ST_NO_PATH;
                    end
                end
                r.idx = 10'(cursor);
            end
            CMD_INVALIDATE:
            begin
                held = 0;
                loading = 0;
                n_points = 0;
                cursor = 0;
            end
            CMD_ADVANCE:
            begin
                if (!held)
                begin
                    cursor = 0;
                    r.status = ST_NO_PATH;
                end
                else
                begin
                    top = n_points - 1;
                    want = b.tgt > cursor ? b.tgt : cursor;
                    if (b.hold && top > 0)
                    begin
                        top--;
                    end
                    cursor = want < top ? want : top;
                end
                r.idx = 10'(cursor);
            end
            CMD_PROGRESS:
            begin
                r.idx = 10'(cursor);
                if (!held)
                begin
                    r.status = ST_NO_PATH;
                    r.distance = 24'hFFFFFF;
                    r.direct = 24'hFFFFFF;
                end
                else
                begin
                    best = 0;
                    best_sq = dist_sq(b.px, b.py, path_x[0], path_y[0]);
                    for (i = 1; i < n_points; i++)
                    begin
                        sq = dist_sq(b.px, b.py, path_x[i], path_y[i]);
                        if (sq < best_sq)
                        begin
                            best_sq = sq;
                            best = i;
                        end
                    end
                    cur = cursor < n_points - 1 ? cursor : n_points - 1;
                    rem = 0;
                    for (i = cur + 1; i <= best && rem < LEN_SAT; i++)
                    begin
                        rem += span_l8(dist_sq(path_x[i-1], path_y[i-1], path_x[i], path_y[i]));
                        if (rem > LEN_SAT)
                        begin
                            rem = LEN_SAT;
                        end
                    end
                    sq = dist_sq(b.rx, b.ry, b.px, b.py);
                    r.direct = round_mm(span_l8(sq));
                    r.distance = round_mm(rem);
                    r.reached = cur >= best || rem <= (thr << 8) || sq <= thr * thr;
                    r.idx = 10'(best);
                end
            end
            CMD_NEAREST:
            begin
                r.idx = 10'(cursor);
                if (!held)
                begin
                    r.status = ST_NO_PATH;
                    r.distance = 24'hFFFFFF;
                end
                else
                begin
                    cur = cursor < n_points - 1 ? cursor : n_points - 1;
                    best_sq = dist_sq(b.px, b.py, path_x[cur], path_y[cur]);
                    r.idx = 10'(cur);
                    for (i = cur + 1; i < n_points; i++)
                    begin
                        sq = dist_sq(b.px, b.py, path_x[i], path_y[i]);
                        if (sq < best_sq)
                        begin
                            best_sq = sq;
                            r.idx = 10'(i);
                        end
                    end
                    r.distance = round_mm(span_l8(best_sq));
                end
            end
            default:
            begin
                r.idx = 10'(cursor);
            end
        endcase
        r.ok = held;
        r.version = commits;
        return r;
    endfunction

    function automatic cmd_beat_t beat(logic [2:0] cmd, int px, int py, int rx, int ry,
                                       bit last, int tgt, bit hold, int thr);
        cmd_beat_t b;
        b.cmd = cmd;
        b.px = 24'(px);
        b.py = 24'(py);
        b.rx = 24'(rx);
        b.ry = 24'(ry);
        b.last = last;
        b.tgt = 10'(tgt);
        b.hold = hold;
        b.thr = 24'(thr);
        return b;
    endfunction

    function automatic track_result_t res(logic [1:0] st, bit ok, int idx, int len_mm,
                                          int direct, bit reached, int ver);
        track_result_t r;
        r.status = st;
        r.ok = ok;
        r.idx = 10'(idx);
        r.distance = 24'(len_mm);
        r.direct = 24'(direct);
        r.reached = reached;
        r.version = 32'(ver);
        return r;
    endfunction

    task automatic add_row(cmd_beat_t b, bit typed, track_result_t r);
        table_beats.push_back(b);
        table_typed.push_back(typed);
        table_result.push_back(r);
    endtask

    task automatic add_free(cmd_beat_t b);
        add_row(b, 0, '{default: '0});
    endtask

    task automatic send(cmd_beat_t b, bit typed, track_result_t typed_res);
        int gap;
        track_result_t r;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata = {5'b0, b.thr, b.hold, b.tgt, b.ry, b.rx, b.py, b.px};
        s_tuser = b.cmd;
        s_tlast = b.last;
        s_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        r = track_step(b);
        expected_results.push_back(typed ? typed_res : r);
        cmd_hits[b.cmd]++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_results.size() > 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // receive side: stall drawn per result beat
    always @(negedge clk)
    begin
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        track_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            rx_stall <= quiet ? 0 : $urandom_range(0, 19);
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected", $time);
            end
            else
            begin
                e = expected_results.pop_front();
                compare("status", 32'(e.status), 32'(m_tuser));
                compare("path_ok", 32'(e.ok), 32'(m_tdata[0]));
                compare("result_index", 32'(e.idx), 32'(m_tdata[10:1]));
                compare("distance_mm", 32'(e.distance), 32'(m_tdata[34:11]));
                compare("direct_goal_mm", 32'(e.direct), 32'(m_tdata[58:35]));
                compare("reached", 32'(e.reached), 32'(m_tdata[59]));
                compare("version", e.version, m_tdata[91:60]);
            end
        end
    end

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 24'($urandom);
            1: return $urandom_range(0, 1) ? C_MAX : C_MIN;
            default: return 24'(($signed($urandom_range(0, 40)) - 20) * 25);
        endcase
    endfunction

    function automatic logic [23:0] rand_thr();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 25));
            default: return 24'($urandom_range(0, 400));
        endcase
    endfunction

    task automatic send_free(cmd_beat_t b);
        send(b, 0, '{default: '0});
        random_sent++;
    endtask

    initial
    begin
        cmd_beat_t     b;
        int            n;
        int            k;
        int            pick;
        errors = 0;
        cycles = 0;
        results_seen = 0;
        random_sent = 0;
        quiet = 0;
        rx_stall = 0;
        foreach (cmd_hits[i]) cmd_hits[i] = 0;
        n_points = 0;
        cursor = 0;
        held = 0;
        loading = 0;
        commits = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_NOP7;
        s_tlast = 1'b0;
        m_tready = 1'b0;

        // no path yet
        add_row(beat(CMD_NEAREST, 5, 5, 0, 0, 0, 0, 0, 0), 1,
                res(ST_NO_PATH, 0, 0, 24'hFFFFFF, 0, 0, 0));
        add_row(beat(CMD_PROGRESS, 5, 5, 1, 1, 0, 0, 0, 0), 1,
                res(ST_NO_PATH, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0));
        add_row(beat(CMD_ADVANCE, 0, 0, 0, 0, 0, 5, 0, 0), 1,
                res(ST_NO_PATH, 0, 0, 0, 0, 0, 0));
        // single point commit is too short
        add_row(beat(CMD_LOAD, 0, 0, 0, 0, 1, 0, 0, 0), 1,
                res(ST_NO_PATH, 0, 0, 0, 0, 0, 0));
        add_row(beat(CMD_LOAD, C_MIN, C_MIN, 0, 0, 0, 0, 0, 0), 1,
                res(ST_OK, 0, 0, 0, 0, 0, 0));
        add_free(beat(CMD_LOAD, C_MAX, C_MAX, 0, 0, 0, 1023, 1, 24'hFFFFFF));
        add_row(beat(CMD_LOAD, 0, 0, 0, 0, 1, 0, 0, 0), 1,
                res(ST_OK, 1, 0, 0, 0, 0, 1));
        add_free(beat(CMD_NEAREST, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0));
        add_free(beat(CMD_PROGRESS, C_MAX, C_MAX, C_MIN, C_MIN, 0, 0, 0, 0));
        add_row(beat(CMD_ADVANCE, 0, 0, 0, 0, 0, 1023, 1, 0), 1,
                res(ST_OK, 1, 1, 0, 0, 0, 1));
        add_free(beat(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_free(beat(CMD_ADVANCE, 0, 0, 0, 0, 0, 1023, 0, 0));
        add_free(beat(CMD_PROGRESS, C_MIN, C_MIN, C_MAX, C_MIN, 0, 0, 0, 24'hFFFFFF));
        add_free(beat(CMD_NOP5, 1, 2, 3, 4, 1, 9, 1, 7));
        add_free(beat(CMD_NOP6, C_MAX, C_MIN, C_MAX, C_MIN, 0, 1023, 0, 24'hFFFFFF));
        add_free(beat(CMD_NOP7, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(beat(CMD_INVALIDATE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                res(ST_OK, 0, 0, 0, 0, 0, 1));
        // open load dropped by invalidate
        add_free(beat(CMD_LOAD, 10, 0, 0, 0, 0, 0, 0, 0));
        add_free(beat(CMD_LOAD, 30, 0, 0, 0, 0, 0, 0, 0));
        add_free(beat(CMD_INVALIDATE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(beat(CMD_NEAREST, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                res(ST_NO_PATH, 0, 0, 24'hFFFFFF, 0, 0, 1));
        add_free(beat(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
        add_free(beat(CMD_LOAD, 100, 0, 0, 0, 0, 0, 0, 0));
        add_free(beat(CMD_LOAD, 100, 100, 0, 0, 1, 0, 0, 0));
        // equal distance to two points keeps the lower index
        add_free(beat(CMD_NEAREST, 50, 0, 0, 0, 0, 0, 0, 0));
        add_free(beat(CMD_PROGRESS, 100, 90, 0, 0, 0, 0, 0, 19));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (table_beats[i])
        begin
            send(table_beats[i], table_typed[i], table_result[i]);
        end
        drain();

        // full path: the last point overflows and still commits the kept ones
        quiet = 1;
        for (k = 0; k <= PATH_DEPTH; k++)
        begin
            send(beat(CMD_LOAD, k * 7, (k % 3) * 5, 0, 0, k == PATH_DEPTH, 0, 0, 0),
                 0, '{default: '0});
        end
        send(beat(CMD_NEAREST, 100000, 0, 0, 0, 0, 0, 0, 0), 0, '{default: '0});
        send(beat(CMD_PROGRESS, 7200, 0, 3, -9, 0, 0, 0, 30), 0, '{default: '0});
        send(beat(CMD_ADVANCE, 0, 0, 0, 0, 0, 1023, 1, 0), 0, '{default: '0});
        send(beat(CMD_INVALIDATE, 0, 0, 0, 0, 0, 0, 0, 0), 0, '{default: '0});
        drain();
        quiet = 0;

        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            quiet = $urandom_range(0, 7) == 0;
            if (pick == 0)
            begin
                // noise: any command, any fields, maybe a stray load
                b = beat(3'($urandom), $urandom, $urandom, $urandom, $urandom,
                         1'($urandom), $urandom, 1'($urandom), $urandom);
                send_free(b);
            end
            else
            begin
                n = $urandom_range(1, 12);
                for (k = 0; k < n; k++)
                begin
                    b = beat(CMD_LOAD, rand_coord(), rand_coord(), 0, 0, k == n - 1,
                             $urandom, 1'($urandom), $urandom);
                    send_free(b);
                end
                repeat ($urandom_range(2, 7))
                begin
                    k = $urandom_range(0, 3);
                    b = beat(CMD_NEAREST, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), 1'($urandom), $urandom, 1'($urandom), rand_thr());
                    if (k == 0)
                    begin
                        b.cmd = CMD_ADVANCE;
                        b.tgt = $urandom_range(0, 3) == 0 ? 10'($urandom)
                                                          : 10'($urandom_range(0, 13));
                    end
                    else if (k == 1)
                    begin
                        b.cmd = CMD_PROGRESS;
                        if (n > 0 && $urandom_range(0, 1))
                        begin
                            pick = $urandom_range(0, n - 1);
                            b.px = 24'(path_x[pick] + $signed($urandom_range(0, 20)) - 10);
                            b.py = 24'(path_y[pick] + $signed($urandom_range(0, 20)) - 10);
                        end
                    end
                    send_free(b);
                end
            end
            if (random_sent > 120 && random_sent < 140)
            begin
                drain();
            end
        end
        drain();
        quiet = 0;
        repeat (60) @(posedge clk);

        $display("%0d result beats checked; loads %0d, invalidates %0d, advances %0d,",
                 results_seen, cmd_hits[CMD_LOAD], cmd_hits[CMD_INVALIDATE],
                 cmd_hits[CMD_ADVANCE]);
        $display("progress queries %0d, nearest queries %0d, other codes %0d",
                 cmd_hits[CMD_PROGRESS], cmd_hits[CMD_NEAREST],
                 cmd_hits[CMD_NOP5] + cmd_hits[CMD_NOP6] + cmd_hits[CMD_NOP7]);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/rppt_pkg.sv
src/rppt_sqrt.sv
src/rppt_dp.sv
src/rppt_ctrl.sv
src/reference_path_progress_tracker.sv
dv/reference_path_progress_tracker_test.sv
